### rtl/hspl_pkg.sv
package hspl_pkg;

	localparam int NUM_POINTS = 16;
	localparam int IDX_W = $clog2(NUM_POINTS);
	localparam int CNT_W = $clog2(NUM_POINTS + 1);

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;
	localparam logic [1:0] ACT_MOVE  = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	// Segment slots loaded before evaluation.
	localparam logic [1:0] SLOT_YM2 = 2'd0;
	localparam logic [1:0] SLOT_P0  = 2'd1;
	localparam logic [1:0] SLOT_P1  = 2'd2;
	localparam logic [1:0] SLOT_YP1 = 2'd3;

	// Steps of the arithmetic sequencer, in issue order.
	localparam logic [3:0] MUL_T2    = 4'd0;
	localparam logic [3:0] MUL_T3    = 4'd1;
	localparam logic [3:0] MUL_BASIS = 4'd2;
	localparam logic [3:0] MUL_H00   = 4'd3;
	localparam logic [3:0] MUL_H01   = 4'd4;
	localparam logic [3:0] MUL_H10   = 4'd5;
	localparam logic [3:0] MUL_H11   = 4'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_point;   // write one point at the item's index
		logic rd_addr;    // present rd_idx to the stores
		logic [IDX_W-1:0] rd_idx;
		logic move_wr;    // write the moved point at rd_idx (read earlier by rd_addr)
		logic cap_first;  // capture first x
		logic cap_last;   // capture last x and y
		logic cap_cmp;    // compare query x against the point just read
		logic cap_seg;    // capture point data into segment slot
		logic [1:0] seg_slot; // 0 y[i-2], 1 point i-1, 2 point i, 3 y[i+1]
		logic seg_end;    // the neighbour of this slot lies past a table end
		logic div_start;
		logic mul_step;   // advance the arithmetic sequencer one step
		logic [3:0] mul_op;
		logic finish;     // drive the result
		logic fin_mode;   // 0 evaluated, 1 last point or outside
	} hspl_cmd_t;

	typedef struct packed {
		logic in_range;
		logic below;      // query x < x of the point just compared
		logic div_done;
	} hspl_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v > 33'sd2147483647) return 32'sh7fffffff;
		if (v < -33'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

### rtl/hspl_div.sv
module hspl_div
	import hspl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,   // x - x0, below den
	input  logic [32:0] den,   // x1 - x0, positive
	output logic        done,
	output logic [15:0] quo
);
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [33:0] trial;

	assign trial = {rem_q[32:0], 1'b0} - {1'b0, den_q};

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd16;
				rem_q <= {1'b0, num};
				den_q <= den;
			end else if (run_q) begin
				if (!trial[33]) begin
					rem_q <= trial;
					quo   <= {quo[14:0], 1'b1};
				end else begin
					rem_q <= {rem_q[32:0], 1'b0};
					quo   <= {quo[14:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
endmodule

### rtl/hspl_datapath.sv
module hspl_datapath
	import hspl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hspl_cmd_t         cmd,
	output hspl_sts_t         sts,
	input  logic [3:0]        index,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	output logic signed [31:0] height,
	output logic              inside_res,
	output logic              strobe
);
	logic signed [31:0] px_mem [NUM_POINTS];
	logic signed [31:0] py_mem [NUM_POINTS];
	logic signed [31:0] rdx_q, rdy_q;
	logic [3:0]  idx_q;
	logic signed [31:0] xv_q, yv_q;
	logic signed [31:0] xf_q, xl_q, yl_q;
	logic signed [31:0] ym2_q, x0_q, y0_q, x1_q, y1_q, yp1_q;
	logic        tz_lo_q, tz_hi_q;
	logic        below_q;
	logic        div_done;
	logic [15:0] t_q;
	logic [47:0] t2_q, t3_q;
	logic signed [49:0] h00_q, h01_q, h10_q, h11_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] prod;
	logic signed [32:0] ma, mb;
	logic signed [29:0] hsel;
	logic signed [33:0] vsel;
	logic signed [32:0] rx, ry;
	logic signed [63:0] rnd;

	// Point stores: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_point && (CNT_W'(idx_q) < CNT_W'(NUM_POINTS))) begin
			px_mem[idx_q[IDX_W-1:0]] <= xv_q;
			py_mem[idx_q[IDX_W-1:0]] <= yv_q;
		end else if (cmd.move_wr) begin
			px_mem[cmd.rd_idx] <= sat32(rx);
			py_mem[cmd.rd_idx] <= sat32(ry);
		end
		if (cmd.rd_addr) begin
			rdx_q <= px_mem[cmd.rd_idx];
			rdy_q <= py_mem[cmd.rd_idx];
		end
	end

	assign rx = 33'(rdx_q) + 33'(xv_q);
	assign ry = 33'(rdy_q) + 33'(yv_q);

	// Item capture and segment registers.
	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= index;
			xv_q  <= x_value;
			yv_q  <= y_value;
		end
		if (cmd.cap_first) xf_q <= rdx_q;
		if (cmd.cap_last) begin
			xl_q <= rdx_q;
			yl_q <= rdy_q;
		end
		if (cmd.cap_cmp) below_q <= xv_q < rdx_q;
		if (cmd.cap_seg) begin
			case (cmd.seg_slot)
				SLOT_YM2: begin ym2_q <= rdy_q; tz_lo_q <= cmd.seg_end; end
				SLOT_P0: begin x0_q <= rdx_q; y0_q <= rdy_q; end
				SLOT_P1: begin x1_q <= rdx_q; y1_q <= rdy_q; end
				default: begin yp1_q <= rdy_q; tz_hi_q <= cmd.seg_end; end
			endcase
		end
	end

	assign sts.in_range = (xv_q >= xf_q) && (xv_q <= xl_q);
	assign sts.below    = below_q;
	assign sts.div_done = div_done;

	hspl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(33'(xv_q) - 33'(x0_q)), .den(33'(x1_q) - 33'(x0_q)),
		.done(div_done), .quo(t_q)
	);

	// Basis weights (Q.28) and operand selection for the shared multiplier.
	// The tangent terms take twice the tangent, y[i] - y[i-2] and y[i+1] - y[i-1],
	// and are zero where the neighbour lies past either end of the table.
	always_comb begin
		ma = '0;
		mb = '0;
		hsel = '0;
		vsel = '0;
		case (cmd.mul_op)
			MUL_T2: begin ma = 33'(t_q); mb = 33'(t_q); end
			MUL_T3: begin ma = 33'(t2_q[31:0]); mb = 33'(t_q); end
			MUL_H00: begin hsel = h00_q[29:0]; vsel = 34'(y0_q) <<< 1; end
			MUL_H01: begin hsel = h01_q[29:0]; vsel = 34'(y1_q) <<< 1; end
			MUL_H10: begin
				hsel = h10_q[29:0];
				vsel = tz_lo_q ? '0 : 34'(y1_q) - 34'(ym2_q);
			end
			MUL_H11: begin
				hsel = h11_q[29:0];
				vsel = tz_hi_q ? '0 : 34'(yp1_q) - 34'(y0_q);
			end
			default: ;
		endcase
	end
	assign prod = (cmd.mul_op >= MUL_H00) ? 64'(hsel) * 64'(vsel) : 64'(ma) * 64'(mb);

	always_ff @(posedge clk) begin
		logic [47:0] tt, t2s, t3s;
		tt  = {t_q, 32'd0};
		t2s = {t2_q[31:0], 16'd0};
		t3s = t3_q;
		if (cmd.mul_step) begin
			case (cmd.mul_op)
				MUL_T2: t2_q <= 48'(prod);
				MUL_T3: t3_q <= 48'(prod);
				MUL_BASIS: begin
					h00_q <= (50'sd1 <<< 48) - 3*$signed({2'b0, t2s})
						+ 2*$signed({2'b0, t3s}) + (50'sd1 <<< 19) >>> 20;
					h01_q <= 3*$signed({2'b0, t2s}) - 2*$signed({2'b0, t3s})
						+ (50'sd1 <<< 19) >>> 20;
					h10_q <= $signed({2'b0, tt}) - 2*$signed({2'b0, t2s})
						+ $signed({2'b0, t3s}) + (50'sd1 <<< 19) >>> 20;
					h11_q <= $signed({2'b0, t3s}) - $signed({2'b0, t2s})
						+ (50'sd1 <<< 19) >>> 20;
					acc_q <= '0;
				end
				default: acc_q <= acc_q + prod;
			endcase
		end
	end

	// Round the weighted sum half up to Q16.16.
	assign rnd = (acc_q + (64'sd1 <<< 28)) >>> 29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe     <= 1'b0;
			inside_res <= 1'b0;
			height     <= '0;
		end else begin
			strobe <= cmd.finish;
			if (cmd.finish) begin
				if (cmd.fin_mode) begin
					inside_res <= sts.in_range;
					height     <= sts.in_range ? yl_q : 32'sd0;
				end else begin
					inside_res <= 1'b1;
					if (rnd > 64'sd2147483647) height <= 32'sh7fffffff;
					else if (rnd < -64'sd2147483648) height <= 32'sh80000000;
					else height <= rnd[31:0];
				end
			end
		end
	end
endmodule

### rtl/hspl_ctrl.sv
module hspl_ctrl
	import hspl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  hspl_sts_t  sts,
	output hspl_cmd_t  cmd,
	output logic       load,
	output logic       busy
);
	typedef enum logic [3:0] {
		S_IDLE, S_WRITE, S_MOVE, S_RDF, S_RDL, S_CHK, S_SRCH, S_SCMP,
		S_SEG, S_DIV, S_MUL, S_DONE
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W:0]   seg_q;
	logic [2:0]       sub_q;
	logic [3:0]       op_q;
	logic             ok_q;

	assign busy = (state_q != S_IDLE);

	// The item is captured at the edge that takes it.
	assign load = start && (state_q == S_IDLE);

	// One clocked block: state and all registered commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd     <= '0;
			i_q     <= '0;
			seg_q   <= '0;
			sub_q   <= '0;
			op_q    <= '0;
			ok_q    <= 1'b0;
		end else begin
			cmd <= '0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q <= '0;
						sub_q <= '0;
						case (action)
							ACT_WRITE: state_q <= S_WRITE;
							ACT_QUERY: state_q <= S_RDF;
							ACT_MOVE:  state_q <= S_MOVE;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_WRITE: begin
					cmd.wr_point <= 1'b1;
					state_q <= S_DONE;
				end
				// Read each point, wait for the store, then write it back moved.
				S_MOVE: begin
					if (sub_q == 3'd0) begin
						cmd.rd_addr <= 1'b1;
						cmd.rd_idx <= i_q;
						sub_q <= 3'd1;
					end else if (sub_q == 3'd1) begin
						sub_q <= 3'd2;
					end else begin
						cmd.move_wr <= 1'b1;
						cmd.rd_idx <= i_q;
						sub_q <= 3'd0;
						i_q <= i_q + 1'b1;
						if (i_q == IDX_W'(NUM_POINTS - 1)) state_q <= S_DONE;
					end
				end
				S_RDF: begin
					if (sub_q == 3'd0) begin
						cmd.rd_addr <= 1'b1; cmd.rd_idx <= '0; sub_q <= 3'd1;
					end else if (sub_q == 3'd1) begin
						sub_q <= 3'd2;
					end else begin
						cmd.cap_first <= 1'b1;
						cmd.rd_addr <= 1'b1; cmd.rd_idx <= IDX_W'(NUM_POINTS - 1);
						sub_q <= 3'd0;
						state_q <= S_RDL;
					end
				end
				S_RDL: begin
					if (sub_q == 3'd0) begin
						cmd.cap_last <= 1'b1;
						sub_q <= 3'd1;
					end else begin
						sub_q <= 3'd0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!sts.in_range) begin
						cmd.finish <= 1'b1; cmd.fin_mode <= 1'b1;
						state_q <= S_DONE;
					end else begin
						i_q <= IDX_W'(1);
						state_q <= S_SRCH;
					end
				end
				// Walk up the table for the first x above the query.
				S_SRCH: begin
					if (sub_q == 3'd0) begin
						cmd.rd_addr <= 1'b1; cmd.rd_idx <= i_q; sub_q <= 3'd1;
					end else if (sub_q == 3'd1) begin
						cmd.cap_cmp <= 1'b1; sub_q <= 3'd2;
					end else if (sub_q == 3'd2) begin
						sub_q <= 3'd3;
					end else begin
						sub_q <= 3'd0;
						if (sts.below) begin
							seg_q <= {1'b0, i_q};
							state_q <= S_SEG;
						end else if (i_q == IDX_W'(NUM_POINTS - 1)) begin
							cmd.finish <= 1'b1; cmd.fin_mode <= 1'b1;
							state_q <= S_DONE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				// Load y[i-2], point i-1, point i, y[i+1]; tangent ends are zero.
				S_SEG: begin
					state_q <= S_SEG;
					if (sub_q == 3'd0) begin
						cmd.rd_addr <= 1'b1;
						case (op_q[1:0])
							SLOT_YM2: cmd.rd_idx <= IDX_W'(seg_q - 2);
							SLOT_P0: cmd.rd_idx <= IDX_W'(seg_q - 1);
							SLOT_P1: cmd.rd_idx <= IDX_W'(seg_q);
							default: cmd.rd_idx <= IDX_W'(seg_q + 1);
						endcase
						sub_q <= 3'd1;
					end else if (sub_q == 3'd1) begin
						sub_q <= 3'd2;
					end else begin
						cmd.cap_seg <= 1'b1;
						cmd.seg_slot <= op_q[1:0];
						cmd.seg_end <= ((op_q[1:0] == SLOT_YM2) && (seg_q < CNT_W'(2)))
							|| ((op_q[1:0] == SLOT_YP1)
							&& (seg_q == CNT_W'(NUM_POINTS - 1)));
						sub_q <= 3'd0;
						op_q <= op_q + 4'd1;
						if (op_q[1:0] == SLOT_YP1) begin
							op_q <= '0;
							ok_q <= 1'b0;
							cmd.div_start <= 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						op_q <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cmd.mul_step <= 1'b1;
					cmd.mul_op <= op_q;
					op_q <= op_q + 4'd1;
					if (op_q == MUL_H11) begin
						op_q <= '0;
						state_q <= S_DONE;
						ok_q <= 1'b1;
					end
				end
				S_DONE: begin
					if (ok_q) begin
						cmd.finish <= 1'b1; cmd.fin_mode <= 1'b0;
						ok_q <= 1'b0;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/hermite_spline_height_lookup_unit.sv
// Catmull-Rom height lookup over a table of 16 control points in Q16.16.
// Command channel: an item is taken when start is high and busy is low.
// action selects a point write, a height query or a move of all points.
// A query gives one result: height and inside_res shown for one cycle with
// strobe high; writes and moves give none. The receiver cannot stall, so a
// result is simply presented once.
// A move reads and writes back every point in turn. A query ends with x
// outside the table, x on the last point, or x in the segment that ends at
// point i; for a segment the block walks the points up to i, reads the four
// segment values, runs the divider that forms t and then seven steps of the
// shared multiplier. The next item can be taken in the strobe cycle. One
// item is in work at a time.
// Reset clears the controller and output strobe; the point stores keep
// whatever they held and are undefined until written.
module hermite_spline_height_lookup_unit
	import hspl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [3:0]         index,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	output logic signed [31:0] height,
	output logic               inside_res,
	output logic               strobe
);
	hspl_cmd_t cmd;
	hspl_sts_t sts;
	logic      load;

	hspl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.sts(sts), .cmd(cmd), .load(load), .busy(busy)
	);

	hspl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .cmd(cmd), .sts(sts),
		.index(index), .x_value(x_value), .y_value(y_value),
		.height(height), .inside_res(inside_res), .strobe(strobe)
	);

	// A result only appears when an item was in work just before it.
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> $past(busy))
		else $error("result without an item in work");
	// An item is only taken when idle, so busy rises after a take.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action != ACT_NOP) |=> busy)
		else $error("item taken without going busy");
	// Outside results carry zero height.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !inside_res) |-> (height == 32'sd0))
		else $error("outside result with nonzero height");
endmodule

### tb/sv/hermite_spline_height_lookup_unit_tb.sv
module hermite_spline_height_lookup_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hspl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 120;

	typedef struct {
		logic signed [31:0] height;
		logic               in_tbl;
	} height_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [3:0]         index;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic signed [31:0] height;
	logic               inside_res;
	logic               strobe;

	// Shadow copy of the control point table.
	logic signed [31:0] shadow_x [NUM_POINTS];
	logic signed [31:0] shadow_y [NUM_POINTS];

	height_t pending_heights[$];
	int      error_count;
	int      items_sent;
	int      queries_sent;
	int      moves_sent;
	int      heights_checked;
	longint  cycle_count = 0;

	hermite_spline_height_lookup_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.index(index),
		.x_value(x_value),
		.y_value(y_value),
		.height(height),
		.inside_res(inside_res),
		.strobe(strobe)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint expv, input longint gotv);
		$display("mismatch %s: expected %0d got %0d (t=%0t)", what, expv, gotv, $realtime);
		error_count++;
	endtask

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Round half up, then drop s fraction bits (arithmetic shift floors).
	function automatic longint round_drop(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Twice the y tangent at a point; zero at both ends.
	function automatic longint twice_tangent(input int i);
		if (i <= 0 || i >= NUM_POINTS - 1) return 0;
		return longint'(shadow_y[i + 1]) - longint'(shadow_y[i - 1]);
	endfunction

	// Cubic Hermite value on the segment that ends at point i.
	function automatic logic signed [31:0] segment_height(input int i, input longint x);
		longint x0;
		longint dx;
		longint unsigned t;
		longint tt;
		longint t2;
		longint t3;
		longint h00;
		longint h01;
		longint h10;
		longint h11;
		longint acc;
		x0 = shadow_x[i - 1];
		dx = longint'(shadow_x[i]) - x0;
		t = (longint'(x - x0) << 16) / longint'(dx);
		tt = t << 32;
		t2 = (t * t) << 16;
		t3 = t * t * t;
		h00 = round_drop((longint'(1) << 48) - 3 * t2 + 2 * t3, 20);
		h01 = round_drop(3 * t2 - 2 * t3, 20);
		h10 = round_drop(tt - 2 * t2 + t3, 20);
		h11 = round_drop(t3 - t2, 20);
		acc = h00 * 2 * longint'(shadow_y[i - 1]) + h01 * 2 * longint'(shadow_y[i])
			+ h10 * twice_tangent(i - 1) + h11 * twice_tangent(i);
		return clamp32(round_drop(acc, 29));
	endfunction

	// Apply one accepted item to the shadow table; queries queue a height.
	task automatic predict_item(input logic [1:0] act, input logic [3:0] idx,
		input logic signed [31:0] xv, input logic signed [31:0] yv);
		height_t h;
		longint x;
		x = xv;
		case (act)
			ACT_WRITE: begin
				shadow_x[idx] = xv;
				shadow_y[idx] = yv;
			end
			ACT_MOVE: begin
				for (int i = 0; i < NUM_POINTS; i++) begin
					shadow_x[i] = clamp32(longint'(shadow_x[i]) + x);
					shadow_y[i] = clamp32(longint'(shadow_y[i]) + longint'(yv));
				end
			end
			ACT_QUERY: begin
				if (x < shadow_x[0] || x > shadow_x[NUM_POINTS - 1]) begin
					h.height = '0;
					h.in_tbl = 1'b0;
				end else begin
					h.height = shadow_y[NUM_POINTS - 1];
					h.in_tbl = 1'b1;
					for (int i = 1; i < NUM_POINTS; i++) begin
						if (x < shadow_x[i]) begin
							h.height = segment_height(i, x);
							break;
						end
					end
				end
				pending_heights.insert(pending_heights.size(), h);
			end
			default: begin
			end
		endcase
	endtask

	// Drive one item after a random gap and hold it until the block takes it.
	task automatic send_item(input logic [1:0] act, input logic [3:0] idx,
		input logic signed [31:0] xv, input logic signed [31:0] yv);
		int gap;
		gap = $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		action = act;
		index = idx;
		x_value = xv;
		y_value = yv;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predict_item(act, idx, xv, yv);
		items_sent++;
		if (act == ACT_QUERY) queries_sent++;
		if (act == ACT_MOVE) moves_sent++;
	endtask

	// Compare each strobed height with the oldest one predicted.
	always @(posedge clk) begin
		height_t e;
		if (arst_n && strobe) begin
			if (pending_heights.size() == 0) begin
				report_mismatch("unexpected result", 0, height);
			end else begin
				e = pending_heights.pop_front();
				if (height !== e.height) report_mismatch("height", e.height, height);
				if (inside_res !== e.in_tbl) report_mismatch("inside_res", e.in_tbl, inside_res);
				heights_checked++;
			end
		end
	end

	// Write a strictly increasing table with random y values.
	task automatic load_sorted_table(input int max_step_log);
		longint x;
		x = -64'sd2147483648 + longint'($urandom_range(0, 32'h7fff_ffff));
		if (x > 64'sd1073741824) x = 64'sd1073741824 - 64'sd2147483648 * longint'($urandom_range(0, 1));
		for (int i = 0; i < NUM_POINTS; i++) begin
			send_item(ACT_WRITE, i[3:0], x[31:0], $urandom);
			x = x + 1 + longint'($urandom_range(0, (1 << max_step_log) - 1));
		end
	endtask

	// A random query: mostly inside the table, sometimes on a point or outside.
	task automatic random_query();
		longint lo;
		longint hi;
		longint q;
		int pick;
		lo = shadow_x[0];
		hi = shadow_x[NUM_POINTS - 1];
		pick = $urandom_range(0, 9);
		if (pick < 6 && hi >= lo) begin
			q = lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1));
		end else if (pick < 8) begin
			q = shadow_x[$urandom_range(0, NUM_POINTS - 1)];
		end else begin
			q = $signed($urandom);
		end
		send_item(ACT_QUERY, 4'($urandom), q[31:0], $urandom);
	endtask

	task automatic test_table_load();
		load_sorted_table(26);
	endtask

	// Points, ends, outside on both sides, saturation and odd actions.
	task automatic test_directed_cases();
		send_item(ACT_QUERY, 4'd0, shadow_x[0], 32'h0);
		send_item(ACT_QUERY, 4'd15, shadow_x[NUM_POINTS - 1], 32'hffff_ffff);
		send_item(ACT_QUERY, 4'd0, shadow_x[0] - 1, 32'h0);
		send_item(ACT_QUERY, 4'd0, shadow_x[NUM_POINTS - 1] + 1, 32'h0);
		send_item(ACT_QUERY, 4'd0, shadow_x[7] - 1, 32'h0);
		send_item(ACT_NOP, 4'd9, 32'h7fff_ffff, 32'h8000_0000);
		// Table spanning the full x range with extreme y swings.
		for (int i = 0; i < NUM_POINTS; i++) begin
			send_item(ACT_WRITE, i[3:0],
				(i == NUM_POINTS - 1) ? 32'sh7fff_ffff : 32'sh8000_0000 + i * 32'sh1000_0000,
				(i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000);
		end
		send_item(ACT_QUERY, 4'd0, 32'sh8000_0000, 32'h0);
		send_item(ACT_QUERY, 4'd0, 32'sh7fff_ffff, 32'h0);
		send_item(ACT_QUERY, 4'd0, 32'sh8800_0000, 32'h0);
		send_item(ACT_QUERY, 4'd0, 32'sh1234_5678, 32'h0);
		// Moves that saturate both coordinates, then back off.
		send_item(ACT_MOVE, 4'd0, 32'sh7fff_ffff, 32'sh7fff_ffff);
		send_item(ACT_QUERY, 4'd0, 32'sh7fff_ffff, 32'h0);
		send_item(ACT_MOVE, 4'd0, 32'sh8000_0000, 32'sh8000_0000);
		send_item(ACT_QUERY, 4'd0, 32'sh0, 32'h0);
	endtask

	// Mostly queries on ordered tables, with moves, rewrites and noise.
	task automatic test_random_traffic(input int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				load_sorted_table($urandom_range(4, 26));
			end else if (pick < 65) begin
				random_query();
			end else if (pick < 80) begin
				send_item(ACT_MOVE, 4'($urandom),
					(pick < 78) ? $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000 : $urandom,
					(pick < 78) ? $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000 : $urandom);
			end else if (pick < 95) begin
				send_item(ACT_WRITE, 4'($urandom), $urandom, $urandom);
			end else begin
				send_item(ACT_NOP, 4'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		start = 1'b0;
		action = ACT_WRITE;
		index = '0;
		x_value = '0;
		y_value = '0;
		error_count = 0;
		items_sent = 0;
		queries_sent = 0;
		moves_sent = 0;
		heights_checked = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_load();
		test_directed_cases();
		test_random_traffic(1040);

		@(negedge clk);
		start = 1'b0;
		while (pending_heights.size() != 0 || busy) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_heights.size() != 0) begin
			$display("%0d heights never arrived", pending_heights.size());
			error_count++;
		end

		$display("Sent %0d items: %0d height queries, %0d table moves.",
			items_sent, queries_sent, moves_sent);
		$display("Checked %0d heights, %0d mismatches.", heights_checked, error_count);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
